// File: rtl/asef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan EMA filter package
// Shared widths, reset values, opcodes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package asef_pkg;

    localparam int OP_W         = 2;
    localparam int PIN_W        = 5;
    localparam int SHIFT_W      = 5;
    localparam int SAMPLE_W     = 12;
    localparam int ACC_W        = 31;
    localparam int READ_W       = 16;
    localparam int PIN_COUNT    = 18;
    localparam int SAMPLE_SCALE = 19;

    localparam logic [SHIFT_W-1:0] FSHIFT_RESET = SHIFT_W'(9);
    localparam logic [SHIFT_W-1:0] OSHIFT_RESET = SHIFT_W'(16);

    localparam int MAX_CHANNELS_DEF = 18;
    localparam int SAMPLE_BITS_DEF  = 12;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic capture;
        logic add_wr;
        logic list_rd;
        logic acc_rd;
        logic acc_sel_list;
        logic acc_wr;
        logic res_ld;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: rtl/asef_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan EMA filter item channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface asef_in_if import asef_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [PIN_W-1:0]    pin;
    logic [SHIFT_W-1:0]  filter_shift;
    logic [SHIFT_W-1:0]  output_shift;
    logic [SAMPLE_W-1:0] sample;

    modport source (
        output valid, opcode, pin, filter_shift, output_shift, sample,
        input  ready
    );

    modport sink (
        input  valid, opcode, pin, filter_shift, output_shift, sample,
        output ready
    );

endinterface
`default_nettype wire

// File: rtl/asef_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan EMA filter result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface asef_out_if import asef_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  next_pin;
    logic              start_conversion;
    logic [READ_W-1:0] read_value;
    logic              add_accepted;

    modport source (
        output valid, next_pin, start_conversion, read_value, add_accepted,
        input  ready
    );

    modport sink (
        input  valid, next_pin, start_conversion, read_value, add_accepted,
        output ready
    );

endinterface
`default_nettype wire

// File: rtl/asef_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan EMA filter controller
// Sequences the datapath through the steps of each item and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module asef_ctrl import asef_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_ADD,
        S_LIST,
        S_ACC,
        S_UPD,
        S_NEXT,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_ADD:    n_state = S_ADD;
                    OP_SAMPLE: n_state = S_LIST;
                    OP_READ: begin
                        w_cmd.acc_rd = 1'b1;
                        n_state      = S_DONE;
                    end
                    default:   n_state = S_DONE;
                endcase
            end
            S_ADD: begin
                w_cmd.add_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_LIST: begin
                w_cmd.list_rd = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                w_cmd.acc_rd       = 1'b1;
                w_cmd.acc_sel_list = 1'b1;
                n_state            = S_UPD;
            end
            S_UPD: begin
                w_cmd.acc_wr = 1'b1;
                n_state      = S_NEXT;
            end
            S_NEXT: begin
                w_cmd.list_rd = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.res_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
`default_nettype wire

// File: rtl/asef_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan EMA filter datapath
// Scan list, per-pin tables, the filter update and the result registers.
// ----------------------------------------------------------------------------
module asef_dp import asef_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [PIN_W-1:0]    i_pin,
    input  wire logic [SHIFT_W-1:0]  i_filter_shift,
    input  wire logic [SHIFT_W-1:0]  i_output_shift,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic [PIN_W-1:0]         o_next_pin,
    output logic                     o_start_conversion,
    output logic [READ_W-1:0]        o_read_value,
    output logic                     o_add_accepted
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Captured item.
    t_opcode             r_op;
    logic [PIN_W-1:0]    r_pin;
    logic [SHIFT_W-1:0]  r_fsh_in;
    logic [SHIFT_W-1:0]  r_osh_in;
    logic [SAMPLE_W-1:0] r_sample;

    // Control state.
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_pos;
    logic [PIN_COUNT-1:0] r_acc_vld;
    logic [PIN_COUNT-1:0] r_osh_vld;

    // Tables.
    logic [PIN_W-1:0]   r_lst_pin_mem [MAX_CHANNELS];
    logic [SHIFT_W-1:0] r_lst_fsh_mem [MAX_CHANNELS];
    logic [ACC_W-1:0]   r_acc_mem     [PIN_COUNT];
    logic [SHIFT_W-1:0] r_osh_mem     [PIN_COUNT];

    // Registered read data.
    logic [PIN_W-1:0]   r_lst_pin;
    logic [SHIFT_W-1:0] r_lst_fsh;
    logic [ACC_W-1:0]   r_acc_q;
    logic [SHIFT_W-1:0] r_osh_q;
    logic               r_add_ok;

    // Result registers.
    logic [PIN_W-1:0]  r_next_pin;
    logic              r_start;
    logic [READ_W-1:0] r_read_val;
    logic              r_add_acc;

    logic                   w_add_ok;
    logic                   w_pin_ok;
    logic [PIN_W-1:0]       w_acc_addr;
    logic                   w_acc_addr_ok;
    logic [CNT_W-1:0]       w_pos_inc;
    logic [CNT_W-1:0]       w_pos_next;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic signed [ACC_W:0]  w_target;
    logic signed [ACC_W:0]  w_acc_s;
    logic signed [ACC_W:0]  w_diff;
    logic signed [ACC_W:0]  w_step;
    logic signed [ACC_W:0]  w_sum;
    logic [ACC_W-1:0]       w_shifted;

    assign w_pin_ok      = (r_pin < PIN_W'(PIN_COUNT));
    assign w_add_ok      = (r_count < CNT_W'(MAX_CHANNELS)) && w_pin_ok;
    assign w_acc_addr    = i_cmd.acc_sel_list ? r_lst_pin : r_pin;
    assign w_acc_addr_ok = (w_acc_addr < PIN_W'(PIN_COUNT));

    assign w_pos_inc  = r_pos + CNT_W'(1);
    assign w_pos_next = ((w_pos_inc >= r_count) || (w_pos_inc >= CNT_W'(MAX_CHANNELS)))
                        ? '0 : w_pos_inc;

    // The difference is shifted arithmetically, which rounds toward minus infinity.
    assign w_raw    = r_sample[SAMPLE_BITS-1:0];
    assign w_target = signed'((ACC_W+1)'(w_raw) << SAMPLE_SCALE);
    assign w_acc_s  = signed'({1'b0, r_acc_q});
    assign w_diff   = w_target - w_acc_s;
    assign w_step   = w_diff >>> r_lst_fsh;
    assign w_sum    = w_acc_s + w_step;

    assign w_shifted = r_acc_q >> r_osh_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_opcode'(i_opcode);
            r_pin    <= i_pin;
            r_fsh_in <= i_filter_shift;
            r_osh_in <= i_output_shift;
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pos     <= '0;
            r_acc_vld <= '0;
            r_osh_vld <= '0;
        end else begin
            if (i_cmd.add_wr && w_add_ok) begin
                r_count          <= r_count + CNT_W'(1);
                r_osh_vld[r_pin] <= 1'b1;
            end
            if (i_cmd.acc_wr) begin
                r_pos <= w_pos_next;
                if (r_lst_pin < PIN_W'(PIN_COUNT)) begin
                    r_acc_vld[r_lst_pin] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr && w_add_ok) begin
            r_lst_pin_mem[r_count[IDX_W-1:0]] <= r_pin;
            r_lst_fsh_mem[r_count[IDX_W-1:0]] <= r_fsh_in;
            r_osh_mem[r_pin]                  <= r_osh_in;
        end
        if (i_cmd.acc_wr && (r_lst_pin < PIN_W'(PIN_COUNT))) begin
            r_acc_mem[r_lst_pin] <= w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            r_add_ok <= w_add_ok;
        end
        if (i_cmd.list_rd) begin
            if (r_pos < r_count) begin
                r_lst_pin <= r_lst_pin_mem[r_pos[IDX_W-1:0]];
                r_lst_fsh <= r_lst_fsh_mem[r_pos[IDX_W-1:0]];
            end else begin
                r_lst_pin <= '0;
                r_lst_fsh <= FSHIFT_RESET;
            end
        end
        if (i_cmd.acc_rd) begin
            if (w_acc_addr_ok && r_acc_vld[w_acc_addr]) begin
                r_acc_q <= r_acc_mem[w_acc_addr];
            end else begin
                r_acc_q <= '0;
            end
            if (w_pin_ok && r_osh_vld[r_pin]) begin
                r_osh_q <= r_osh_mem[r_pin];
            end else begin
                r_osh_q <= OSHIFT_RESET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_next_pin <= (r_op == OP_SAMPLE) ? r_lst_pin : '0;
            r_start    <= (r_op == OP_SAMPLE);
            r_read_val <= ((r_op == OP_READ) && w_pin_ok) ? w_shifted[READ_W-1:0] : '0;
            r_add_acc  <= (r_op == OP_ADD) && r_add_ok;
        end
    end

    assign o_sts.op           = r_op;
    assign o_next_pin         = r_next_pin;
    assign o_start_conversion = r_start;
    assign o_read_value       = r_read_val;
    assign o_add_accepted     = r_add_acc;

endmodule
`default_nettype wire

// File: rtl/adc_scan_channel_ema_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC scan channel EMA filter core
// Round-robin converter scan list with one exponential moving average
// filter per pin.
//
// Items arrive on i_item and results leave on o_res; both are valid/ready
// channels, and a transfer happens on a clock edge with valid and ready high.
// Each item gives exactly one result. An add item appends a pin to the scan
// list, a sample item updates the filter of the pin at the scan position and
// reports the next pin to convert, and a read item returns a filtered value.
// The block takes one item at a time. An add runs the dispatch, add and done
// steps, a read or an opcode of three runs dispatch and done, and a sample
// runs dispatch, list read, accumulator read, update, next-pin read and done
// through the list and accumulator tables, the longest sequence. The block is
// ready for the next item in the cycle after the result is loaded. The result
// sits in an output register, so a stalled receiver holds it while the block
// finishes the next item, which then waits in the last step until the register
// is free. Reset empties the scan list, clears every accumulator and sets the
// default shifts, taking effect on the next clock edge with no clearing pass.
// ----------------------------------------------------------------------------
module adc_scan_channel_ema_filter_core import asef_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    asef_in_if.sink    i_item,
    asef_out_if.source o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    asef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    asef_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_opcode           (i_item.opcode),
        .i_pin              (i_item.pin),
        .i_filter_shift     (i_item.filter_shift),
        .i_output_shift     (i_item.output_shift),
        .i_sample           (i_item.sample),
        .o_next_pin         (o_res.next_pin),
        .o_start_conversion (o_res.start_conversion),
        .o_read_value       (o_res.read_value),
        .o_add_accepted     (o_res.add_accepted)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the ADC scan channel EMA filter core
// Items are driven into the block on the item channel, and each transfer is
// run through a behavioral copy of the scan list and filter tables to predict
// its result. Results are taken off the result channel and compared field by
// field, in order. Directed tests cover reset defaults, out-of-range pins,
// refused adds and the extreme filter shifts, then a long random mix fills
// the scan list and exercises wrap, full-list refusals and reads. Both sides
// insert random idle gaps, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb;
    import asef_pkg::*;

    localparam int SCAN_DEPTH  = MAX_CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [PIN_W-1:0]  next_pin;
        logic              start_conversion;
        logic [READ_W-1:0] read_value;
        logic              add_accepted;
    } t_filter_result;

    logic clk = 1'b0;
    logic rst_n;

    asef_in_if  item_if ();
    asef_out_if res_if ();

    adc_scan_channel_ema_filter_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    logic [PIN_W-1:0]   list_pin    [SCAN_DEPTH];
    logic [SHIFT_W-1:0] list_fshift [SCAN_DEPTH];
    logic [SHIFT_W-1:0] pin_oshift  [PIN_COUNT];
    logic [ACC_W-1:0]   pin_acc     [PIN_COUNT];
    int                 list_len;
    int                 scan_pos;

    t_filter_result pending_results [$];
    t_filter_result want;

    bit calm = 1'b0;
    int stall_left = 0;
    int cycles = 0;
    int errors = 0;
    int n_items = 0;
    int n_adds_ok = 0;
    int n_adds_refused = 0;
    int n_samples = 0;
    int n_reads = 0;
    int n_checked = 0;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_filter_result filter_step(t_opcode op, logic [PIN_W-1:0] pin,
                                                   logic [SHIFT_W-1:0] fs,
                                                   logic [SHIFT_W-1:0] os,
                                                   logic [SAMPLE_W-1:0] smp);
        t_filter_result r;
        int pos;
        logic [PIN_W-1:0] p;
        logic [SAMPLE_W-1:0] raw;
        longint target;
        longint diff;
        longint step;
        r = '0;
        case (op)
            OP_ADD: begin
                if (list_len < SCAN_DEPTH && pin < PIN_COUNT) begin
                    list_pin[list_len] = pin;
                    list_fshift[list_len] = fs;
                    pin_oshift[pin] = os;
                    list_len++;
                    r.add_accepted = 1'b1;
                end
            end
            OP_SAMPLE: begin
                raw = smp & SAMPLE_W'((1 << SAMPLE_BITS_DEF) - 1);
                pos = (scan_pos < SCAN_DEPTH) ? scan_pos : 0;
                p = list_pin[pos];
                if (p < PIN_COUNT) begin
                    target = longint'(raw) << SAMPLE_SCALE;
                    diff = target - longint'(pin_acc[p]);
                    step = diff >>> list_fshift[pos];
                    pin_acc[p] = ACC_W'(longint'(pin_acc[p]) + step);
                end
                pos++;
                if (pos >= list_len || pos >= SCAN_DEPTH) pos = 0;
                scan_pos = pos;
                r.next_pin = list_pin[pos];
                r.start_conversion = 1'b1;
            end
            OP_READ: begin
                if (pin < PIN_COUNT) r.read_value = READ_W'(pin_acc[pin] >> pin_oshift[pin]);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(t_opcode op, logic [PIN_W-1:0] pin, logic [SHIFT_W-1:0] fs,
                             logic [SHIFT_W-1:0] os, logic [SAMPLE_W-1:0] smp);
        int gap;
        t_filter_result r;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.opcode       <= op;
        item_if.pin          <= pin;
        item_if.filter_shift <= fs;
        item_if.output_shift <= os;
        item_if.sample       <= smp;
        do @(posedge clk); while (!item_if.ready);
        r = filter_step(op, pin, fs, os, smp);
        pending_results.push_back(r);
        n_items++;
        if (op == OP_ADD && r.add_accepted) n_adds_ok++;
        if (op == OP_ADD && !r.add_accepted) n_adds_refused++;
        if (op == OP_SAMPLE) n_samples++;
        if (op == OP_READ) n_reads++;
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            res_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no item outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (res_if.next_pin !== want.next_pin) begin
                    $error("next_pin: expected %0d, got %0d", want.next_pin, res_if.next_pin);
                    errors++;
                end
                if (res_if.start_conversion !== want.start_conversion) begin
                    $error("start_conversion: expected %0d, got %0d",
                           want.start_conversion, res_if.start_conversion);
                    errors++;
                end
                if (res_if.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, res_if.read_value);
                    errors++;
                end
                if (res_if.add_accepted !== want.add_accepted) begin
                    $error("add_accepted: expected %0d, got %0d",
                           want.add_accepted, res_if.add_accepted);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending_results.size());
            $display("tb failed");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_item(OP_READ, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd17, 5'd31, 5'd31, 12'hfff);
        send_item(OP_READ, 5'd18, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd31, 5'd0, 5'd0, 12'd0);
        send_item(OP_NOP, 5'd31, 5'd31, 5'd31, 12'hfff);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'hfff);
        send_item(OP_READ, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_SAMPLE, 5'd31, 5'd31, 5'd31, 12'd0);
        send_item(OP_READ, 5'd0, 5'd0, 5'd0, 12'd0);
    endtask

    task automatic test_list_add();
        send_item(OP_ADD, 5'd31, 5'd3, 5'd3, 12'd0);
        send_item(OP_ADD, 5'd18, 5'd3, 5'd3, 12'd0);
        send_item(OP_ADD, 5'd17, 5'd0, 5'd0, 12'd0);
        send_item(OP_ADD, 5'd0, 5'd31, 5'd31, 12'd0);
        send_item(OP_ADD, 5'd5, 5'd4, 5'd12, 12'd0);
    endtask

    task automatic test_filter_extremes();
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'hfff);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'hfff);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'hfff);
        send_item(OP_READ, 5'd17, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd5, 5'd0, 5'd0, 12'd0);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_SAMPLE, 5'd0, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd17, 5'd0, 5'd0, 12'd0);
        send_item(OP_READ, 5'd0, 5'd0, 5'd0, 12'd0);
    endtask

    task automatic test_random_mix(int count);
        int k;
        int r;
        t_opcode op;
        logic [PIN_W-1:0] pin;
        logic [SHIFT_W-1:0] os;
        for (k = 0; k < count; k++) begin
            calm = (k % 100) >= 80;
            r = $urandom_range(0, 99);
            if (r < 15) op = OP_ADD;
            else if (r < 60) op = OP_SAMPLE;
            else if (r < 92) op = OP_READ;
            else op = OP_NOP;
            if ($urandom_range(0, 99) < 85) pin = PIN_W'($urandom_range(0, PIN_COUNT - 1));
            else pin = PIN_W'($urandom_range(PIN_COUNT, 31));
            if ($urandom_range(0, 1) == 1) os = SHIFT_W'($urandom_range(8, 20));
            else os = SHIFT_W'($urandom());
            send_item(op, pin, SHIFT_W'($urandom()), os, SAMPLE_W'($urandom()));
        end
        calm = 1'b0;
    endtask

    initial begin
        int i;
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.opcode       = OP_NOP;
        item_if.pin          = '0;
        item_if.filter_shift = '0;
        item_if.output_shift = '0;
        item_if.sample       = '0;
        res_if.ready         = 1'b0;
        for (i = 0; i < SCAN_DEPTH; i++) begin
            list_pin[i]    = '0;
            list_fshift[i] = FSHIFT_RESET;
        end
        for (i = 0; i < PIN_COUNT; i++) begin
            pin_oshift[i] = OSHIFT_RESET;
            pin_acc[i]    = '0;
        end
        list_len = 0;
        scan_pos = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_list_add();
        test_filter_extremes();
        test_random_mix(400);

        @(negedge clk);
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d items: %0d adds stored, %0d refused, %0d samples, %0d reads.",
                 n_items, n_adds_ok, n_adds_refused, n_samples, n_reads);
        $display("Checked %0d results; scan list ended with %0d entries.", n_checked, list_len);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: adc_scan_channel_ema_filter_core.f
rtl/asef_pkg.sv
rtl/asef_in_if.sv
rtl/asef_out_if.sv
rtl/asef_ctrl.sv
rtl/asef_dp.sv
rtl/adc_scan_channel_ema_filter_core.sv
tb/sv/tb.sv
